// ----- src/smfb_pkg.sv -----
// Shared types, constants and table functions for the softmax forward/backward block.
package smfb_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_BWD = 1'b1;

    localparam int VAL_W     = 16;
    localparam int EXP_W     = 32;
    localparam int OUT_W     = 17;
    localparam int QUO_W     = 16;
    localparam int DIV_NUM_W = 47;
    localparam int OUT_MAX   = 65535;
    localparam int OUT_MIN   = -65536;

    localparam logic [63:0] ONE_Q31      = 64'h8000_0000;
    localparam logic [63:0] HALF_Q31     = 64'h4000_0000;
    localparam logic [63:0] EXP_M1_Q31   = 64'd790015084;

    // exp(-n) in Q0.31, built by repeated multiplication with exp(-1).
    function automatic logic [31:0] exp_int_val(input int n);
        logic [63:0] v;
        int i;
        v = ONE_Q31;
        for (i = 0; i < 16; i++) begin
            if (i < n) begin
                v = (v * EXP_M1_Q31 + HALF_Q31) >> 31;
            end
        end
        return v[31:0];
    endfunction

    // exp(-k/2^bits) in Q0.31 from a truncated alternating Taylor series.
    function automatic logic [31:0] exp_frac_val(input int k, input int bits);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        int i;
        term = ONE_Q31;
        pos  = ONE_Q31;
        neg  = 64'd0;
        for (i = 1; i <= 16; i++) begin
            term = ((term * 64'(k)) >> bits) / 64'(i);
            if ((i % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return 32'(pos - neg);
    endfunction

endpackage

// ----- src/softmax_forward_backward.sv -----
// Top level: element store, probability store and the pass sequencer.
//
//  channel   dir  tdata              tuser                     tlast
//  s_axis    in   in_value[15:0]     command[0], training[1]   in_last
//  m_axis    out  out_value[16:0]    status[1:0]               out_last
//
// Elements are loaded one per cycle until the word with tlast.
// A forward pass then computes the exp of each element and then the probabilities
// of each element through the 16-step bit-serial divider.
// A backward pass first forms the dot product over all elements, then the results.
// Reset is synchronous; no clearing pass is needed.
// Input is taken only while loading; a stalled output holds the sequencer.
module softmax_forward_backward #(
    parameter int MAX_LEN        = 64,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // in_value[15:0]
    input  logic [1:0]  i_s_axis_tuser,   // command[0], training[1]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_value[16:0], zeros above
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    output logic        o_m_axis_tlast
);
    import smfb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SUM_W  = 32 + IDX_W;
    localparam int GS_W   = 32 + IDX_W;
    localparam int DIFF_W = GS_W + 1;
    localparam int PROD_W = DIFF_W + 17;

    typedef enum logic [3:0] {
        S_LOAD, S_E_RD, S_E_GO, S_E_WAIT, S_D_RD, S_D_GO, S_D_WAIT,
        S_B_RD, S_B_MUL, S_B_ACC, S_G_RD, S_G_DIFF, S_G_MUL, S_G_OUT, S_Z
    } t_state;

    t_state r_state;

    logic [31:0]       mem_a [MAX_LEN];
    logic [15:0]       mem_p [MAX_LEN];
    logic [31:0]       r_a_rd;
    logic [15:0]       r_p_rd;

    logic [CNT_W-1:0]  r_load_cnt;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_prob_cnt;
    logic              r_prob_valid;
    logic signed [15:0] r_max;
    logic              r_ovf;
    t_status           r_st;
    logic              r_train;
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic signed [GS_W-1:0]   r_gsum;
    logic signed [32:0]       r_gp;
    logic signed [DIFF_W-1:0] r_diff;
    logic [15:0]              r_yb;
    logic signed [PROD_W-1:0] r_bp;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_oval;
    logic              r_olast;
    t_status           r_ost;

    logic              w_s_acc;
    logic              w_room;
    logic signed [15:0] w_x;
    logic [CNT_W-1:0]  w_n_new;
    logic              w_end;
    logic              w_slot_free;
    logic              w_out_load;
    logic [OUT_W-1:0]  w_out_val;
    t_status           w_out_st;
    logic signed [15:0] w_g;
    logic signed [16:0] w_dx;
    logic              w_exp_start;
    logic              w_exp_valid;
    logic [EXP_W-1:0]  w_exp;
    logic              w_div_start;
    logic              w_div_done;
    logic [QUO_W-1:0]  w_quo;
    logic [DIV_NUM_W-1:0] w_num;
    logic signed [PROD_W-1:0] w_t;
    logic signed [PROD_W-1:0] w_v;
    logic [OUT_W-1:0]  w_sat;
    logic              w_a_we;
    logic [IDX_W-1:0]  w_a_addr;
    logic [31:0]       w_a_data;
    logic              w_p_we;

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_s_acc  = i_s_axis_tvalid && (r_state == S_LOAD);
    assign w_room   = (r_load_cnt < CNT_W'(MAX_LEN));
    assign w_x      = $signed(i_s_axis_tdata);
    assign w_n_new  = w_room ? r_load_cnt + CNT_W'(1) : r_load_cnt;
    assign w_end    = (CNT_W'(r_idx) == r_n - CNT_W'(1));
    assign w_g      = $signed(r_a_rd[15:0]);
    assign w_dx     = {r_max[15], r_max} - {w_g[15], w_g};

    assign w_exp_start = (r_state == S_E_GO);
    assign w_div_start = (r_state == S_D_GO);
    assign w_num = {r_a_rd, 15'd0} + DIV_NUM_W'(r_sum >> 1);

    // Gradient result: round half up at bit 27, then clamp to the output range.
    assign w_t = r_bp + $signed(PROD_W'(64'd1 << 26));
    assign w_v = w_t >>> 27;
    always_comb begin
        if (w_v > OUT_MAX) begin
            w_sat = OUT_W'(OUT_MAX);
        end else if (w_v < OUT_MIN) begin
            w_sat = OUT_W'(OUT_MIN);
        end else begin
            w_sat = w_v[OUT_W-1:0];
        end
    end

    assign w_slot_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        w_out_load = 1'b0;
        w_out_val  = '0;
        w_out_st   = r_st;
        case (r_state)
            S_D_WAIT: begin
                w_out_load = w_slot_free && w_div_done;
                w_out_val  = OUT_W'(w_quo);
            end
            S_G_OUT: begin
                w_out_load = w_slot_free;
                w_out_val  = w_sat;
            end
            S_Z: begin
                w_out_load = w_slot_free;
                w_out_st   = ST_NOMATCH;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_a_we   = 1'b0;
        w_a_addr = r_idx;
        w_a_data = w_exp;
        if (w_s_acc && w_room) begin
            w_a_we   = 1'b1;
            w_a_addr = r_load_cnt[IDX_W-1:0];
            w_a_data = {16'd0, i_s_axis_tdata};
        end else if ((r_state == S_E_WAIT) && w_exp_valid) begin
            w_a_we = 1'b1;
        end
    end

    assign w_p_we = (r_state == S_D_WAIT) && w_out_load && r_train;

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            mem_a[w_a_addr] <= w_a_data;
        end
        r_a_rd <= mem_a[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            mem_p[r_idx] <= w_quo;
        end
        r_p_rd <= mem_p[r_idx];
    end

    smfb_exp #(
        .TB(EXP_TABLE_BITS)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_exp_start),
        .i_diff  (w_dx[15:0]),
        .o_valid (w_exp_valid),
        .o_exp   (w_exp)
    );

    smfb_div #(
        .DEN_W(SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_load_cnt   <= '0;
            r_n          <= '0;
            r_prob_cnt   <= '0;
            r_prob_valid <= 1'b0;
            r_max        <= 16'sh8000;
            r_ovf        <= 1'b0;
            r_st         <= ST_OK;
            r_train      <= 1'b0;
            r_idx        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_oval   <= w_out_val;
                r_olast  <= w_end;
                r_ost    <= w_out_st;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (w_s_acc) begin
                        if (w_room) begin
                            r_load_cnt <= r_load_cnt + CNT_W'(1);
                            if (w_x > r_max) begin
                                r_max <= w_x;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_n        <= w_n_new;
                            r_st       <= (r_ovf || !w_room) ? ST_TRUNC : ST_OK;
                            r_train    <= i_s_axis_tuser[1];
                            r_load_cnt <= '0;
                            r_ovf      <= 1'b0;
                            r_idx      <= '0;
                            r_sum      <= '0;
                            r_gsum     <= '0;
                            if (i_s_axis_tuser[0] == CMD_FWD) begin
                                r_state <= S_E_RD;
                            end else begin
                                r_max        <= 16'sh8000;
                                r_prob_valid <= 1'b0;
                                r_prob_cnt   <= '0;
                                if (r_prob_valid && (r_prob_cnt == w_n_new)) begin
                                    r_state <= S_B_RD;
                                end else begin
                                    r_state <= S_Z;
                                end
                            end
                        end
                    end
                end
                S_E_RD:   r_state <= S_E_GO;
                S_E_GO:   r_state <= S_E_WAIT;
                S_E_WAIT: begin
                    if (w_exp_valid) begin
                        r_sum <= r_sum + SUM_W'(w_exp);
                        if (w_end) begin
                            r_idx   <= '0;
                            r_max   <= 16'sh8000;
                            r_state <= S_D_RD;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_D_RD:   r_state <= S_D_GO;
                S_D_GO:   r_state <= S_D_WAIT;
                S_D_WAIT: begin
                    if (w_out_load) begin
                        if (w_end) begin
                            if (r_train) begin
                                r_prob_cnt   <= r_n;
                                r_prob_valid <= 1'b1;
                            end
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_D_RD;
                        end
                    end
                end
                S_B_RD:   r_state <= S_B_MUL;
                S_B_MUL: begin
                    r_gp    <= w_g * $signed({1'b0, r_p_rd});
                    r_state <= S_B_ACC;
                end
                S_B_ACC: begin
                    r_gsum <= r_gsum + GS_W'(r_gp);
                    if (w_end) begin
                        r_idx   <= '0;
                        r_state <= S_G_RD;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_G_RD:   r_state <= S_G_DIFF;
                S_G_DIFF: begin
                    r_diff  <= (DIFF_W'(w_g) <<< 15) - DIFF_W'(r_gsum);
                    r_yb    <= r_p_rd;
                    r_state <= S_G_MUL;
                end
                S_G_MUL: begin
                    r_bp    <= r_diff * $signed({1'b0, r_yb});
                    r_state <= S_G_OUT;
                end
                S_G_OUT, S_Z: begin
                    if (w_out_load) begin
                        if (w_end) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= (r_state == S_Z) ? S_Z : S_G_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_oval};
    assign o_m_axis_tuser  = r_ost;
    assign o_m_axis_tlast  = r_olast;

    // The final word of a vector always hands control back to loading.
    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load && w_end |=> r_state == S_LOAD)
        else $error("sequencer did not return to loading after the final word");

    // Exp results only arrive while the exp pass waits for them.
    a_exp_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exp_valid |-> r_state == S_E_WAIT)
        else $error("exp result outside the exp pass");

    // Kept probabilities always describe a non-empty vector.
    a_prob_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prob_valid |-> r_prob_cnt != '0)
        else $error("kept probabilities with zero count");

    // A word is never overwritten while it waits for the sink.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_m_axis_tready |-> !w_out_load)
        else $error("output word overwritten while stalled");

endmodule

// ----- src/smfb_exp.sv -----
// Two-stage fixed-point exp(-d) unit: table lookup, then product with rounding.
module smfb_exp #(
    parameter int TB = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [smfb_pkg::VAL_W-1:0] i_diff,
    output logic                      o_valid,
    output logic [smfb_pkg::EXP_W-1:0] o_exp
);
    import smfb_pkg::*;

    localparam int FRAC_N = 2 ** TB;

    logic [31:0] w_int_tab  [16];
    logic [31:0] w_frac_tab [FRAC_N];
    logic [31:0] r_a;
    logic [31:0] r_f;
    logic [63:0] r_prod;
    logic [63:0] w_rnd;
    logic        r_v1;
    logic        r_v2;

    for (genvar g = 0; g < 16; g++) begin : g_int
        localparam logic [31:0] IV = exp_int_val(g);
        assign w_int_tab[g] = IV;
    end

    for (genvar g = 0; g < FRAC_N; g++) begin : g_frac
        localparam logic [31:0] FV = exp_frac_val(g, TB);
        assign w_frac_tab[g] = FV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_a    <= w_int_tab[i_diff[15:12]];
        r_f    <= w_frac_tab[i_diff[11 -: TB]];
        r_prod <= 64'(r_a) * 64'(r_f);
    end

    assign w_rnd   = r_prod + HALF_Q31;
    assign o_exp   = w_rnd[62:31];
    assign o_valid = r_v2;

endmodule

// ----- src/smfb_div.sv -----
// Restoring divider, one quotient bit per cycle, result held until the next start.
module smfb_div #(
    parameter int DEN_W = 38
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smfb_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic                          o_done,
    output logic [smfb_pkg::QUO_W-1:0]    o_quo
);
    import smfb_pkg::*;

    localparam int CW = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_low;
    logic [QUO_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_fin;
    logic [DEN_W:0]   w_t;
    logic             w_ge;

    assign w_t  = {r_rem, r_low[QUO_W-1]};
    assign w_ge = (w_t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            // The quotient always fits in QUO_W bits, so the upper part is below the divisor.
            r_busy <= 1'b1;
            r_fin  <= 1'b0;
            r_cnt  <= CW'(QUO_W);
            r_rem  <= DEN_W'(i_num >> QUO_W);
            r_low  <= i_num[QUO_W-1:0];
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_t - {1'b0, r_den}) : w_t[DEN_W-1:0];
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    assign o_done = r_fin;
    assign o_quo  = r_quo;

endmodule
